FILE: rtl/core/content_length_deframer_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef CONTENT_LENGTH_DEFRAMER_ASSERT_SVH
`define CONTENT_LENGTH_DEFRAMER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CLD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CLD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/clen_pkg.sv
`timescale 1ns / 1ps
package clen_pkg;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 25;
	localparam int KEY_W   = 4;
	localparam int TERM_W  = 2;
	localparam int KEY_LEN = 15;

	localparam logic [LEN_W-1:0] LEN_CAP    = 25'h1FF_FFFF;
	localparam logic [LEN_W-1:0] HARD_LIMIT = 25'd16777216;

	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CH_C     = 8'h43;

	typedef enum logic [1:0] {
		KIND_BODY    = 2'd0,
		KIND_NO_KEY  = 2'd1,
		KIND_BAD_LEN = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		NUM_SKIP   = 2'd0,
		NUM_DIGITS = 2'd1,
		NUM_DONE   = 2'd2
	} num_stage_t;

	typedef enum logic {
		PH_HEADER = 1'b0,
		PH_BODY   = 1'b1
	} phase_t;

	typedef struct packed {
		logic             done;
		logic             no_key;
		logic             bad_len;
		logic [LEN_W-1:0] length;
	} hdr_evt_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} beat_t;

	function automatic logic [BYTE_W-1:0] key_char(input logic [KEY_W-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			4'd0:    c = 8'h43;
			4'd1:    c = 8'h6F;
			4'd2:    c = 8'h6E;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h6E;
			4'd6:    c = 8'h74;
			4'd7:    c = 8'h2D;
			4'd8:    c = 8'h4C;
			4'd9:    c = 8'h65;
			4'd10:   c = 8'h6E;
			4'd11:   c = 8'h67;
			4'd12:   c = 8'h74;
			4'd13:   c = 8'h68;
			4'd14:   c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/clen_hdr.sv
`timescale 1ns / 1ps
module clen_hdr (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [clen_pkg::BYTE_W-1:0]         data_byte,
	input  logic [clen_pkg::LEN_W-1:0]          limit,
	output clen_pkg::hdr_evt_t                  evt
);
	import clen_pkg::*;

	logic [KEY_W-1:0]  key_q, key_n;
	logic              found_q, found_n;
	num_stage_t        stage_q, stage_n;
	logic              neg_q, neg_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [TERM_W-1:0] term_q, term_n;
	logic              hdr_end;
	logic              is_space;
	logic              is_digit;
	logic [3:0]        digit;
	logic [LEN_W+3:0]  acc;
	logic [LEN_W-1:0]  limit_eff;

	assign is_space  = (data_byte == CH_SP) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
	assign is_digit  = (data_byte >= CH_0) && (data_byte <= CH_9);
	assign digit     = 4'(data_byte - CH_0);
	assign acc       = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0} + {25'd0, digit};
	assign limit_eff = (limit > HARD_LIMIT) ? HARD_LIMIT : limit;

	always_comb begin
		key_n   = key_q;
		found_n = found_q;
		stage_n = stage_q;
		neg_n   = neg_q;
		len_n   = len_q;
		if (!found_q) begin
			if ((key_q != KEY_W'(KEY_LEN)) && (data_byte == key_char(key_q))) begin
				key_n = key_q + 4'd1;
			end else begin
				key_n = (data_byte == CH_C) ? 4'd1 : 4'd0;
			end
			if (key_n == KEY_W'(KEY_LEN)) begin
				found_n = 1'b1;
				key_n   = '0;
				stage_n = NUM_SKIP;
			end
		end else begin
			case (stage_q)
				NUM_SKIP: begin
					if (is_space) begin
						stage_n = NUM_SKIP;
					end else if ((data_byte == CH_MINUS) || (data_byte == CH_PLUS)) begin
						neg_n   = (data_byte == CH_MINUS);
						stage_n = NUM_DIGITS;
					end else if (is_digit) begin
						len_n   = {21'd0, digit};
						stage_n = NUM_DIGITS;
					end else begin
						stage_n = NUM_DONE;
					end
				end
				NUM_DIGITS: begin
					if (is_digit) begin
						len_n = (acc > {4'd0, LEN_CAP}) ? LEN_CAP : acc[LEN_W-1:0];
					end else begin
						stage_n = NUM_DONE;
					end
				end
				default: begin
					stage_n = stage_q;
				end
			endcase
		end
	end

	always_comb begin
		hdr_end = 1'b0;
		if (data_byte == CH_CR) begin
			term_n = (term_q == 2'd2) ? 2'd3 : 2'd1;
		end else if ((data_byte == CH_LF) && (term_q == 2'd1)) begin
			term_n = 2'd2;
		end else if ((data_byte == CH_LF) && (term_q == 2'd3)) begin
			term_n  = 2'd0;
			hdr_end = 1'b1;
		end else begin
			term_n = 2'd0;
		end
	end

	assign evt.done    = step && hdr_end;
	assign evt.no_key  = !found_n;
	assign evt.bad_len = (len_n == '0) || neg_n || (len_n > limit_eff);
	assign evt.length  = len_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			found_q <= 1'b0;
			stage_q <= NUM_SKIP;
			neg_q   <= 1'b0;
			len_q   <= '0;
			term_q  <= '0;
		end else if (step) begin
			if (hdr_end) begin
				key_q   <= '0;
				found_q <= 1'b0;
				stage_q <= NUM_SKIP;
				neg_q   <= 1'b0;
				len_q   <= '0;
				term_q  <= '0;
			end else begin
				key_q   <= key_n;
				found_q <= found_n;
				stage_q <= stage_n;
				neg_q   <= neg_n;
				len_q   <= len_n;
				term_q  <= term_n;
			end
		end
	end

endmodule

FILE: rtl/core/clen_body.sv
`timescale 1ns / 1ps
module clen_body (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [clen_pkg::BYTE_W-1:0] data_byte,
	input  clen_pkg::hdr_evt_t          evt,
	output clen_pkg::phase_t            phase,
	output logic                        remain_zero,
	output clen_pkg::beat_t             res
);
	import clen_pkg::*;

	phase_t           phase_q, phase_n;
	logic [LEN_W-1:0] remain_q, remain_n;
	logic             fin;

	assign fin         = (remain_q <= 25'd1);
	assign phase       = phase_q;
	assign remain_zero = (remain_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			remain_q <= '0;
		end else begin
			phase_q  <= phase_n;
			remain_q <= remain_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		remain_n  = remain_q;
		res.valid = 1'b0;
		res.kind  = KIND_BODY;
		res.data  = '0;
		res.last  = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				if (evt.done) begin
					if (evt.no_key) begin
						res.valid = 1'b1;
						res.kind  = KIND_NO_KEY;
					end else if (evt.bad_len) begin
						res.valid = 1'b1;
						res.kind  = KIND_BAD_LEN;
					end else begin
						phase_n  = PH_BODY;
						remain_n = evt.length;
					end
				end
			end
			PH_BODY: begin
				if (step) begin
					res.valid = 1'b1;
					res.data  = data_byte;
					res.last  = fin;
					if (fin) begin
						phase_n  = PH_HEADER;
						remain_n = '0;
					end else begin
						remain_n = remain_q - 25'd1;
					end
				end
			end
			default: begin
				phase_n = PH_HEADER;
			end
		endcase
	end

endmodule

FILE: rtl/core/content_length_deframer.sv
// Path: a beat accepted into the input register is parsed between the registers, and
// its result beat, if any, enters the result register once the master side is free.
// Throughput: one beat per cycle unless the output stalls (single-pass parse).
// Reset: arst_n clears all parse and body state asynchronously and sets the
// length limit to 16777216.
`timescale 1ns / 1ps
`include "content_length_deframer_assert.svh"
module content_length_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [clen_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [clen_pkg::BYTE_W-1:0] m_axis_tdata,   // [7:0] body_byte
	output logic [1:0]                  m_axis_tuser,   // [1:0] kind
	output logic                        m_axis_tlast,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [clen_pkg::LEN_W-1:0]  cfg_data        // [24:0] max_body_length
);
	import clen_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              out_free;
	logic              adv;
	logic [LEN_W-1:0]  max_len_q;
	phase_t            phase;
	logic              remain_zero;
	hdr_evt_t          evt;
	beat_t             res;
	logic              valid_s2;
	kind_t             kind_s2;
	logic [BYTE_W-1:0] data_s2;
	logic              last_s2;

	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= HARD_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
		end
	end

	clen_hdr u_hdr (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv && (phase == PH_HEADER)),
		.data_byte (data_s1),
		.limit     (max_len_q),
		.evt       (evt)
	);

	clen_body u_body (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv),
		.data_byte   (data_s1),
		.evt         (evt),
		.phase       (phase),
		.remain_zero (remain_zero),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.valid) begin
			kind_s2 <= res.kind;
			data_s2 <= res.data;
			last_s2 <= res.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;

	`CLD_ASSERT_IMP(a_drop_clean, m_axis_tvalid && (m_axis_tuser != KIND_BODY), !m_axis_tlast && (m_axis_tdata == '0), "drop beat carries data or last")
	`CLD_ASSERT_IMP(a_body_remain, phase == PH_BODY, !remain_zero, "body phase with nothing left to pass")
	`CLD_ASSERT_IMP(a_ready_stall, !s_axis_tready, valid_s1 && m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")
	`CLD_ASSERT_NXT(a_last_ends, m_axis_tvalid && m_axis_tready && m_axis_tlast, phase == PH_HEADER || valid_s1, "frame end did not return to header")

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import clen_pkg::*;

	localparam int    STALL_LIMIT  = 2000;
	localparam int    DRAIN_CYCLES = 8;
	localparam string KEY_TEXT     = "Content-Length:";

	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;
	} exp_beat_t;

	class frame_scoreboard;
		logic [LEN_W-1:0] limit_reg;
		phase_t           ph;
		logic [2:0]       term;
		logic [3:0]       key_idx;
		logic             key_seen;
		num_stage_t       stage;
		logic             neg;
		logic [LEN_W-1:0] len_acc;
		logic [LEN_W-1:0] remaining;
		exp_beat_t        expected_beats[$];
		int               errors;

		function new();
			limit_reg = HARD_LIMIT;
			remaining = '0;
			errors = 0;
			clear_hdr();
		endfunction

		function void clear_hdr();
			ph = PH_HEADER;
			term = '0;
			key_idx = '0;
			key_seen = 1'b0;
			stage = NUM_SKIP;
			neg = 1'b0;
			len_acc = '0;
		endfunction

		function bit parse_byte(input logic [BYTE_W-1:0] b, output exp_beat_t r);
			logic [2:0]       t;
			longint unsigned  acc;
			logic [LEN_W-1:0] eff;
			logic             digit;
			r = '{kind: KIND_BODY, data: '0, last: 1'b0};
			digit = (b >= CH_0 && b <= CH_9);
			if (ph == PH_BODY) begin
				r.data = b;
				r.last = (remaining <= LEN_W'(1));
				if (r.last) begin
					remaining = '0;
					clear_hdr();
				end else begin
					remaining--;
				end
				return 1'b1;
			end
			if (!key_seen) begin
				if (key_idx < KEY_LEN && b == KEY_TEXT[key_idx])
					key_idx++;
				else
					key_idx = (b == CH_C) ? 4'd1 : 4'd0;
				if (key_idx >= KEY_LEN) begin
					key_seen = 1'b1;
					key_idx = '0;
					stage = NUM_SKIP;
				end
			end else if (stage == NUM_SKIP) begin
				if (b == CH_MINUS || b == CH_PLUS) begin
					neg = (b == CH_MINUS);
					stage = NUM_DIGITS;
				end else if (digit) begin
					len_acc = LEN_W'(b - CH_0);
					stage = NUM_DIGITS;
				end else if (!(b == CH_SP || (b >= CH_TAB && b <= CH_CR))) begin
					stage = NUM_DONE;
				end
			end else if (stage == NUM_DIGITS) begin
				if (digit) begin
					acc = 64'(len_acc) * 64'd10 + 64'(b - CH_0);
					len_acc = (acc > 64'(LEN_CAP)) ? LEN_CAP : acc[LEN_W-1:0];
				end else begin
					stage = NUM_DONE;
				end
			end
			if (b == CH_CR)
				t = (term == 3'd2) ? 3'd3 : 3'd1;
			else if (b == CH_LF && term == 3'd1)
				t = 3'd2;
			else if (b == CH_LF && term == 3'd3)
				t = 3'd4;
			else
				t = 3'd0;
			if (t < 3'd4) begin
				term = t;
				return 1'b0;
			end
			eff = (limit_reg < HARD_LIMIT) ? limit_reg : HARD_LIMIT;
			if (!key_seen) begin
				clear_hdr();
				r.kind = KIND_NO_KEY;
				return 1'b1;
			end
			if (len_acc == '0 || neg || len_acc > eff) begin
				clear_hdr();
				r.kind = KIND_BAD_LEN;
				return 1'b1;
			end
			remaining = len_acc;
			clear_hdr();
			ph = PH_BODY;
			return 1'b0;
		endfunction

		function void note_byte(input logic [BYTE_W-1:0] b);
			exp_beat_t r;
			if (parse_byte(b, r))
				expected_beats.insert(expected_beats.size(), r);
		endfunction

		function void check_beat(input logic [1:0] k, input logic [BYTE_W-1:0] d,
				input logic l);
			exp_beat_t e;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: kind %0d data %02h last %0d", k, d, l);
				errors++;
				return;
			end
			e = expected_beats[0];
			expected_beats.delete(0);
			if (k !== e.kind) begin
				$error("kind: expected %0d, got %0d", e.kind, k);
				errors++;
			end
			if (d !== e.data) begin
				$error("body_byte: expected %02h, got %02h", e.data, d);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [BYTE_W-1:0] s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [BYTE_W-1:0] m_axis_tdata;
	logic [1:0]        m_axis_tuser;
	logic              m_axis_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [LEN_W-1:0]  cfg_data;

	frame_scoreboard   board = new();
	frame_scoreboard   shadow = new();
	logic [BYTE_W-1:0] stim_q[$];
	bit                steady = 1'b0;
	int                stall_cycles = 0;

	content_length_deframer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		exp_beat_t r;
		void'(shadow.parse_byte(b, r));
		stim_q.insert(stim_q.size(), b);
	endfunction

	function automatic void push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic void push_crlf();
		push_byte(CH_CR);
		push_byte(CH_LF);
	endfunction

	function automatic logic [BYTE_W-1:0] filler_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(0, 255));
		while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] ws_byte();
		case ($urandom_range(0, 3))
			0: return CH_SP;
			1: return CH_TAB;
			2: return 8'h0B;
			default: return 8'h0C;
		endcase
	endfunction

	function automatic void push_filler_line();
		repeat ($urandom_range(1, 8)) push_byte(BYTE_W'($urandom_range(8'h61, 8'h7A)));
		push_str(": ");
		repeat ($urandom_range(0, 12)) push_byte(filler_byte());
		push_crlf();
	endfunction

	function automatic void push_length_line();
		int unsigned r;
		int unsigned eff;
		int unsigned cap;
		int unsigned v;
		push_str(KEY_TEXT);
		repeat ($urandom_range(0, 3)) push_byte(ws_byte());
		r = $urandom_range(0, 99);
		if (r < 10)
			push_byte(CH_MINUS);
		else if (r < 20)
			push_byte(CH_PLUS);
		if ($urandom_range(0, 9) == 0)
			push_str("00");
		eff = (shadow.limit_reg < HARD_LIMIT) ? shadow.limit_reg : HARD_LIMIT;
		cap = (eff == 0 || eff > 24) ? 24 : eff;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			push_byte(BYTE_W'($urandom_range(CH_0 + 1, CH_9)));
			repeat ($urandom_range(9, 12)) push_byte(BYTE_W'($urandom_range(CH_0, CH_9)));
		end else begin
			if (r < 66)
				v = $urandom_range(1, cap);
			else if (r < 74)
				v = (eff <= 40) ? eff : cap;
			else if (r < 84)
				v = eff + 1;
			else if (r < 90)
				v = 0;
			else
				v = $urandom_range(HARD_LIMIT + 1, LEN_CAP);
			push_str($sformatf("%0d", v));
		end
		if ($urandom_range(0, 4) == 0)
			push_str(" bytes");
		push_crlf();
	endfunction

	// finish the header in progress, then fill out any body it opened
	function automatic void close_frame();
		while (shadow.ph == PH_BODY || shadow.term != 0 || shadow.key_idx != 0 ||
				shadow.key_seen || shadow.stage != NUM_SKIP || shadow.neg ||
				shadow.len_acc != 0) begin
			if (shadow.ph == PH_BODY)
				push_byte(BYTE_W'($urandom_range(0, 255)));
			else
				push_byte(shadow.term[0] ? CH_LF : CH_CR);
		end
	endfunction

	function automatic void push_frame();
		int unsigned r;
		r = $urandom_range(0, 99);
		repeat ($urandom_range(0, 2)) push_filler_line();
		if (r < 72) begin
			push_length_line();
		end else if (r < 86) begin
			push_str(KEY_TEXT.substr(0, $urandom_range(0, 13)));
			push_byte(filler_byte());
			push_crlf();
		end else begin
			repeat ($urandom_range(1, 30)) push_byte(BYTE_W'($urandom_range(0, 255)));
		end
		if (r < 86) begin
			repeat ($urandom_range(0, 1)) push_filler_line();
			push_crlf();
		end
		close_frame();
	endfunction

	function automatic void push_phase(input int n);
		while (stim_q.size() < n)
			push_frame();
	endfunction

	function automatic void push_header(input string s);
		push_str(s);
		push_crlf();
		push_crlf();
	endfunction

	function automatic void push_directed();
		push_crlf();
		push_crlf();
		push_header("Content-Length:1");
		push_byte(8'hFF);
		push_header("Content-Length: \t+3");
		push_byte(8'h00);
		push_byte(CH_CR);
		push_byte(CH_LF);
		push_header("CContent-Length:-2");
		push_header("Content-Length:0");
		push_header("Content-Length:");
		push_header("Content-Length:x5");
		push_header("Content-Length:99999999999");
		push_header("Content-Length:16777217");
		push_header("content-length:5");
		push_header("Content-Length:2Content-Length:7");
		push_str("ab");
		push_byte(CH_CR);
		push_header("");
		push_header("Content-Length:  -0");
		close_frame();
	endfunction

	task automatic run_stim();
		while (stim_q.size() != 0) begin
			@(negedge clk);
			if (!steady && $urandom_range(0, 99) < 13) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= stim_q[0];
				stim_q.delete(0);
				do @(posedge clk); while (!s_axis_tready);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (board.expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LEN_W-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		board.limit_reg = v;
		shadow.limit_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 13);
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_byte(s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_beat(m_axis_tuser, m_axis_tdata, m_axis_tlast);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_directed();
		push_phase(260);
		run_stim();

		write_limit(LEN_W'(1));
		push_phase(200);
		run_stim();

		write_limit('0);
		push_phase(130);
		run_stim();

		// hold both sides busy for a whole phase
		steady = 1'b1;
		write_limit(LEN_CAP);
		push_header("Content-Length:16777217");
		push_phase(210);
		run_stim();
		steady = 1'b0;

		write_limit(LEN_W'(7));
		push_header("Content-Length:7");
		close_frame();
		push_header("Content-Length:8");
		push_phase(210);
		run_stim();

		write_limit(LEN_W'($urandom_range(2, 40)));
		push_phase(210);
		run_stim();

		write_limit(HARD_LIMIT);
		push_phase(210);
		run_stim();

		wait_drained();
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/clen_pkg.sv
rtl/core/clen_hdr.sv
rtl/core/clen_body.sv
rtl/core/content_length_deframer.sv
tb/sv/tb_top.sv
